// ===== hw/rtl/sedh_pkg.sv =====
// ============================================================================
// sedh_pkg
// Shared constants, types and helpers for the serpentine error-diffusion
// halftoner.
// ============================================================================
package sedh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int FRAC_BITS  = 4;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int PIX_W     = 8;
    localparam int ERR_W     = 16;
    localparam int WCFG_W    = 11;
    localparam int HCFG_W    = 13;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd600;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd400;
    localparam logic [THR_W-1:0]  THR_RESET    = 8'd128;

    localparam logic [WCFG_W-1:0] WIDTH_MIN  = WCFG_W'(2);
    localparam logic [WCFG_W-1:0] WIDTH_MAX  = WCFG_W'(MAX_WIDTH);
    localparam logic [HCFG_W-1:0] HEIGHT_MIN = HCFG_W'(1);
    localparam logic [HCFG_W-1:0] HEIGHT_MAX = HCFG_W'(MAX_HEIGHT);

    localparam logic [PIX_W-1:0] WHITE_PIXEL = 8'd255;
    localparam logic [PIX_W-1:0] BLACK_PIXEL = 8'd0;

    localparam int SUM_W = ERR_W + 2;

    // Position information for one pixel, produced by the scan sequencer.
    typedef struct packed {
        logic [COL_W-1:0] pos;
        logic [COL_W-1:0] behind;
        logic             has_behind;
        logic             last_col;
        logic             last_row;
        logic             first_row;
    } scan_t;

    // Saturate a widened sum to the signed error range.
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (ERR_W - 1)) - 1);
        lo = -SUM_W'(1 << (ERR_W - 1));
        if (v > hi) begin
            sat_err = hi[ERR_W-1:0];
        end
        else if (v < lo) begin
            sat_err = lo[ERR_W-1:0];
        end
        else begin
            sat_err = v[ERR_W-1:0];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] sx_err(input logic signed [ERR_W-1:0] v);
        sx_err = {{(SUM_W - ERR_W){v[ERR_W-1]}}, v};
    endfunction

endpackage

// ===== hw/rtl/sedh_line_mem.sv =====
// ============================================================================
// sedh_line_mem
// Error line store: one write port and one registered read port, with the
// write data returned when a read hits the address written on the same edge.
// ============================================================================
module sedh_line_mem
    import sedh_pkg::*;
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [COL_W-1:0]        waddr,
    input  logic signed [ERR_W-1:0] wdata,
    input  logic                    re,
    input  logic [COL_W-1:0]        raddr,
    output logic signed [ERR_W-1:0] rdata
);

    logic signed [ERR_W-1:0] mem [MAX_WIDTH];
    logic signed [ERR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sedh_scan_seq.sv =====
// ============================================================================
// sedh_scan_seq
// Serpentine scan sequencer: column, row and direction counters, and the
// line store position of the next pixel.
// ============================================================================
module sedh_scan_seq
    import sedh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WCFG_W-1:0] image_width,
    input  logic [HCFG_W-1:0] image_height,
    input  logic              advance,
    output scan_t             scan
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             rev_reg, rev_next;

    logic [WCFG_W-1:0] w_eff, w_dec;
    logic [HCFG_W-1:0] h_eff, h_dec;
    logic [COL_W-1:0]  wm1, c;
    logic [ROW_W-1:0]  hm1;

    always_comb
    begin
        priority if (image_width < WIDTH_MIN)
        begin
            w_eff = WIDTH_MIN;
        end
        else if (image_width > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        else
        begin
            w_eff = image_width;
        end

        priority if (image_height < HEIGHT_MIN)
        begin
            h_eff = HEIGHT_MIN;
        end
        else if (image_height > HEIGHT_MAX)
        begin
            h_eff = HEIGHT_MAX;
        end
        else
        begin
            h_eff = image_height;
        end

        w_dec = w_eff - 1'b1;
        h_dec = h_eff - 1'b1;
        wm1   = w_dec[COL_W-1:0];
        hm1   = h_dec[ROW_W-1:0];

        // A column count left beyond a narrowed row counts as the last one.
        c = (col_reg > wm1) ? wm1 : col_reg;

        scan.pos        = rev_reg ? (wm1 - c) : c;
        scan.behind     = rev_reg ? (scan.pos + 1'b1) : (scan.pos - 1'b1);
        scan.has_behind = (c != '0);
        scan.last_col   = (c == wm1);
        scan.last_row   = (row_reg >= hm1);
        scan.first_row  = (row_reg == '0);

        col_next = col_reg;
        row_next = row_reg;
        rev_next = rev_reg;
        if (advance)
        begin
            if (scan.last_col)
            begin
                col_next = '0;
                if (scan.last_row)
                begin
                    row_next = '0;
                    rev_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    rev_next = ~rev_reg;
                end
            end
            else
            begin
                col_next = c + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rev_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rev_reg <= rev_next;
        end
    end

endmodule

// ===== hw/rtl/sedh_diffuse.sv =====
// ============================================================================
// sedh_diffuse
// Quantiser and error spreader: adds the diffused error to the pixel, picks
// black or white and splits the error into the 7/16, 5/16, 3/16 and 1/16
// shares, keeping the in-row accumulators.
// ============================================================================
module sedh_diffuse
    import sedh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [PIX_W-1:0]        pixel,
    input  logic signed [ERR_W-1:0] below,
    input  logic [THR_W-1:0]        threshold,
    input  logic                    last_col,
    input  logic                    update,
    output logic                    white,
    output logic signed [ERR_W-1:0] behind_err,
    output logic signed [ERR_W-1:0] below_err
);

    localparam int PROD_W = ERR_W + 3;

    logic signed [ERR_W-1:0] ahead_reg, ahead_next;
    logic signed [ERR_W-1:0] pend_behind_reg, pend_behind_next;
    logic signed [ERR_W-1:0] pend_below_reg, pend_below_next;

    logic signed [SUM_W-1:0]  sum_wide;
    logic signed [ERR_W-1:0]  sum, thr_fx, level, err;
    logic signed [PROD_W-1:0] e_x, p7, p5, p3, q7, q5, q3;
    logic signed [ERR_W-1:0]  s7, s5, s3, s1;

    always_comb
    begin
        sum_wide = $signed({{(SUM_W - PIX_W - FRAC_BITS){1'b0}}, pixel, {FRAC_BITS{1'b0}}})
                 + sx_err(ahead_reg) + sx_err(below);
        sum    = sat_err(sum_wide);
        thr_fx = $signed({{(ERR_W - THR_W - FRAC_BITS){1'b0}}, threshold, {FRAC_BITS{1'b0}}});
        white  = (sum >= thr_fx);
        level  = white
               ? $signed({{(ERR_W - PIX_W - FRAC_BITS){1'b0}}, WHITE_PIXEL, {FRAC_BITS{1'b0}}})
               : '0;
        // A white decision only follows a non-negative sum, so this cannot wrap.
        err = sum - level;

        e_x = {{(PROD_W - ERR_W){err[ERR_W-1]}}, err};
        p7  = (e_x <<< 3) - e_x;
        p5  = (e_x <<< 2) + e_x;
        p3  = (e_x <<< 1) + e_x;
        q7  = p7 >>> FRAC_BITS;
        q5  = p5 >>> FRAC_BITS;
        q3  = p3 >>> FRAC_BITS;
        s7  = q7[ERR_W-1:0];
        s5  = q5[ERR_W-1:0];
        s3  = q3[ERR_W-1:0];
        s1  = err >>> FRAC_BITS;

        behind_err = sat_err(sx_err(pend_behind_reg) + sx_err(s3));
        below_err  = sat_err(sx_err(pend_below_reg) + sx_err(s5));

        ahead_next       = ahead_reg;
        pend_behind_next = pend_behind_reg;
        pend_below_next  = pend_below_reg;
        if (update)
        begin
            if (last_col)
            begin
                ahead_next       = '0;
                pend_behind_next = '0;
                pend_below_next  = '0;
            end
            else
            begin
                ahead_next       = s7;
                pend_behind_next = below_err;
                pend_below_next  = s1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg       <= '0;
            pend_behind_reg <= '0;
            pend_below_reg  <= '0;
        end
        else
        begin
            ahead_reg       <= ahead_next;
            pend_behind_reg <= pend_behind_next;
            pend_below_reg  <= pend_below_next;
        end
    end

endmodule

// ===== hw/rtl/serpentine_error_diffusion_halftone.sv =====
// ============================================================================
// serpentine_error_diffusion_halftone
// Serpentine error-diffusion halftoner, top level.
// ============================================================================
// Grey pixels enter on in_valid / in_stall / pixel_in in serpentine order:
// even rows of a frame left to right, odd rows right to left. Each accepted
// transaction gives exactly one result on out_valid / out_stall with
// pixel_out (0 or 255), row_end and frame_end.
// An accepted input goes through the input register and then the output
// register to out_valid. One pixel is taken every cycle unless the output
// stalls: the scan sequencer issues the line store read when the pixel is
// accepted, and the quantiser runs from the input into the output register.
// The line store has one write port; the extra write at the end of a row is
// parked in a holding register and written with the first pixel of the next
// row, with reads forwarded from it meanwhile.
// After reset the line store is cleared, one entry a cycle, over all 1024
// entries; in_stall stays high during that pass. Configuration writes must
// be made only while no pixel is in flight; the block does not enforce it.
// When out_stall is high the output register holds, the input register
// fills, and in_stall then rises in the same cycle until the output moves.
// ============================================================================
module serpentine_error_diffusion_halftone
    import sedh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 row_end,
    output logic                 frame_end
);

    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [THR_W-1:0]  thr_reg;

    logic             clr_active_reg;
    logic [COL_W-1:0] clr_addr_reg;

    scan_t scan;
    logic  in_accept, s1_move;

    logic                    s1_valid_reg;
    scan_t                   s1_scan_reg;
    logic [PIX_W-1:0]        s1_pixel_reg;
    logic                    s1_hit_reg, s1_hit_next;
    logic signed [ERR_W-1:0] s1_hit_data_reg;

    logic                    hold_valid_reg, hold_valid_next;
    logic [COL_W-1:0]        hold_addr_reg, hold_addr_next;
    logic signed [ERR_W-1:0] hold_data_reg, hold_data_next;

    logic                    mem_we;
    logic [COL_W-1:0]        mem_waddr;
    logic signed [ERR_W-1:0] mem_wdata, mem_rdata;

    logic signed [ERR_W-1:0] below;
    logic                    white;
    logic signed [ERR_W-1:0] behind_err, below_err;

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_out_reg;
    logic                    row_end_reg, frame_end_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WCFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HCFG_W-1:0];
                REG_THRESHOLD:    thr_reg    <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------- clear pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------------- handshake
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_active_reg || (s1_valid_reg && !s1_move);
    assign in_accept = in_valid && !in_stall;

    sedh_scan_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .advance      (in_accept),
        .scan         (scan)
    );

    // ------------------------------------------------ line store write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = hold_addr_reg;
        mem_wdata = hold_data_reg;
        priority if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (s1_move && s1_scan_reg.has_behind)
        begin
            mem_we    = 1'b1;
            mem_waddr = s1_scan_reg.behind;
            mem_wdata = behind_err;
        end
        else if (s1_move && hold_valid_reg)
        begin
            // The first pixel of a row has no behind share, so the parked
            // end-of-row entry takes the port.
            mem_we = 1'b1;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_addr_next  = hold_addr_reg;
        hold_data_next  = hold_data_reg;
        priority if (s1_move && s1_scan_reg.last_col)
        begin
            hold_valid_next = 1'b1;
            hold_addr_next  = s1_scan_reg.pos;
            hold_data_next  = below_err;
        end
        else if (s1_move && !s1_scan_reg.has_behind)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
        s1_hit_next = hold_valid_next && (hold_addr_next == scan.pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_addr_reg <= hold_addr_next;
        hold_data_reg <= hold_data_next;
    end

    sedh_line_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_accept),
        .raddr (scan.pos),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------ input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_scan_reg     <= scan;
            s1_pixel_reg    <= pixel_in;
            s1_hit_reg      <= s1_hit_next;
            s1_hit_data_reg <= hold_data_next;
        end
    end

    // ------------------------------------------------------------ quantiser
    always_comb
    begin
        priority if (s1_scan_reg.first_row)
        begin
            below = '0;
        end
        else if (s1_hit_reg)
        begin
            below = s1_hit_data_reg;
        end
        else
        begin
            below = mem_rdata;
        end
    end

    sedh_diffuse u_diffuse (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (s1_pixel_reg),
        .below      (below),
        .threshold  (thr_reg),
        .last_col   (s1_scan_reg.last_col),
        .update     (s1_move),
        .white      (white),
        .behind_err (behind_err),
        .below_err  (below_err)
    );

    // ----------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            pixel_out_reg <= white ? WHITE_PIXEL : BLACK_PIXEL;
            row_end_reg   <= s1_scan_reg.last_col;
            frame_end_reg <= s1_scan_reg.last_col && s1_scan_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    // ----------------------------------------------------------- assertions
    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    a_pixel_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out == WHITE_PIXEL) || (pixel_out == BLACK_PIXEL))
        else $error("pixel_out is neither black nor white");

    a_hold_excludes_behind: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_scan_reg.has_behind |-> !hold_valid_reg)
        else $error("parked row-end entry competes with a behind write");

    a_row_end_parks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_scan_reg.last_col |=> hold_valid_reg)
        else $error("row-end entry was not parked");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !out_valid_reg)
        else $error("transaction in flight during line store clear");

endmodule
